### rtl/fpw_pkg.sv
package fpw_pkg;

  localparam int unsigned TablePages = 64;
  localparam int unsigned PageShift = 12;
  localparam int unsigned PageW = $clog2(TablePages);
  localparam int unsigned AddrW = PageW + 9;
  localparam int unsigned FreeW = $clog2(TablePages + 1);

  localparam logic [1:0] ActLookup = 2'd0;
  localparam logic [1:0] ActMap    = 2'd1;
  localparam logic [1:0] ActUnmap  = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNomem  = 2'd1;
  localparam logic [1:0] StRemap  = 2'd2;
  localparam logic [1:0] StAbsent = 2'd3;

  localparam logic [63:0] FlagLink = 64'h7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_LEAF,
    S_DONE,
    S_INIT
  } state_e;

  typedef struct packed {
    logic          we;
    logic [AddrW-1:0] waddr;
    logic [63:0]   wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/fpw_store.sv
module fpw_store (
  input  logic              clk_i,
  input  fpw_pkg::mem_req_t req_i,
  output logic [63:0]       rdata_o
);
  import fpw_pkg::*;

  logic [63:0] mem [TablePages*512];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

### rtl/fpw_walk.sv
module fpw_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [39:0]          base_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [35:0]          virt_page_i,
  input  logic [39:0]          phys_page_i,
  input  logic [11:0]          perm_i,
  input  logic                 create_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [63:0]          entry_value_o,
  output logic [14:0]          entry_index_o,
  output fpw_pkg::mem_req_t    req_o,
  input  logic [63:0]          rdata_i
);
  import fpw_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  act_q;
  logic [35:0] vp_q;
  logic [39:0] pp_q;
  logic [11:0] perm_q;
  logic        alloc_q;
  logic [1:0]  lvl_q, lvl_d;
  logic [PageW-1:0] page_q, page_d;
  logic [FreeW-1:0] free_q, free_d;
  logic [8:0]  clr_q, clr_d;
  logic [1:0]  st_q, st_d;
  logic [63:0] val_q, val_d;
  logic [14:0] idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [1:0]  res_st_q;
  logic [63:0] res_val_q;
  logic [14:0] res_idx_q;

  logic [8:0]       lidx;
  logic [AddrW-1:0] at;
  logic [39:0]      rel;

  always_comb begin
    case (lvl_q)
      2'd3:    lidx = vp_q[35:27];
      2'd2:    lidx = vp_q[26:18];
      2'd1:    lidx = vp_q[17:9];
      default: lidx = vp_q[8:0];
    endcase
  end

  assign at    = {page_q, lidx};
  assign rel   = rdata_i[PageShift+39:PageShift] - base_i;

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    page_d  = page_q;
    free_d  = free_q;
    clr_d   = clr_q;
    st_d    = st_q;
    val_d   = val_q;
    idx_d   = idx_q;
    ov_d    = ov_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_INIT: begin
        clr_d = clr_q + 9'd1;
        if (clr_q == 9'h1ff) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          lvl_d  = 2'd3;
          page_d = '0;
          if (action_i > ActUnmap) begin
            st_d = StAbsent;
            val_d = '0;
            idx_d = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (lvl_q == 2'd0) begin
          st_d  = StOk;
          val_d = rdata_i;
          idx_d = 15'(at);
          if (act_q == ActMap) begin
            if (rdata_i[0]) begin
              st_d = StRemap;
            end else begin
              val_d = {12'd0, pp_q, perm_q};
            end
          end else if (act_q == ActUnmap && !rdata_i[0]) begin
            st_d = StAbsent;
          end
          state_d = S_DONE;
        end else if (rdata_i[0]) begin
          if (rel >= 40'(TablePages)) begin
            st_d = StNomem;
            val_d = '0;
            idx_d = '0;
            state_d = S_DONE;
          end else begin
            page_d  = PageW'(rel);
            lvl_d   = lvl_q - 2'd1;
            state_d = S_READ;
          end
        end else if (!alloc_q) begin
          st_d = StAbsent;
          val_d = '0;
          idx_d = '0;
          state_d = S_DONE;
        end else if (free_q >= FreeW'(TablePages)) begin
          st_d = StNomem;
          val_d = '0;
          idx_d = '0;
          state_d = S_DONE;
        end else begin
          clr_d   = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        clr_d = clr_q + 9'd1;
        if (clr_q == 9'h1ff) begin
          page_d  = PageW'(free_q);
          free_d  = free_q + FreeW'(1);
          lvl_d   = lvl_q - 2'd1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_o.we    = 1'b0;
    req_o.waddr = at;
    req_o.wdata = '0;
    req_o.raddr = at;
    in_ready_o  = (state_q == S_IDLE);
    case (state_q)
      S_INIT: begin
        req_o.we    = 1'b1;
        req_o.waddr = {PageW'(0), clr_q};
      end
      S_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.waddr = {PageW'(free_q), clr_q};
        if (clr_q == 9'h1ff) begin
          req_o.we    = 1'b1;
        end
      end
      S_EVAL: begin
        if (lvl_q == 2'd0) begin
          if (act_q == ActMap && !rdata_i[0]) begin
            req_o.we    = 1'b1;
            req_o.wdata = {12'd0, pp_q, perm_q};
          end else if (act_q == ActUnmap && rdata_i[0]) begin
            req_o.we    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      free_q  <= FreeW'(1);
      clr_q   <= '0;
      ov_q    <= 1'b0;
      lvl_q   <= '0;
      page_q  <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      lvl_q   <= lvl_d;
      page_q  <= page_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    val_q <= val_d;
    idx_q <= idx_d;
    if (state_q == S_IDLE && in_valid_i) begin
      act_q   <= action_i;
      vp_q    <= virt_page_i;
      pp_q    <= phys_page_i;
      perm_q  <= perm_i;
      alloc_q <= (action_i == ActMap) || (action_i == ActLookup && create_i);
    end
    if (state_q == S_DONE && (!ov_q || out_ready_i)) begin
      res_st_q  <= st_q;
      res_val_q <= val_q;
      res_idx_q <= idx_q;
    end
  end

  // the link entry is written by the top through the store's single port, registered from the last clear write
  assign out_valid_o   = ov_q;
  assign status_o      = res_st_q;
  assign entry_value_o = res_val_q;
  assign entry_index_o = res_idx_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> free_q < FreeW'(TablePages))
    else $error("clear beyond store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_EVAL))
    else $error("read not followed by eval");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("ready while busy");

endmodule

### rtl/four_level_page_table_walker_core.sv
// channel   dir  fields
// s_axis    in   tdata: action[1:0] virt_page[37:2] phys_page[77:38] perm[89:78]
//                create[90]
// m_axis    out  tdata: status[1:0] entry_value[65:2] entry_index[80:66]
// cfg       in   table_base_page, written when cfg_we_i is high
// After reset a pass clears the root page; no item is taken meanwhile.
// Each walk level reads its entry through the store's single registered read port
// (states READ then EVAL); each level allocated adds a pass clearing the new page.
// One item at a time; the result register frees the input side while the result waits to be taken.
module four_level_page_table_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // action, virt_page, phys_page, perm, create
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o   // status, entry_value, entry_index
);
  import fpw_pkg::*;

  logic [39:0] base_q;
  mem_req_t    req, req_w;
  logic [63:0] rdata;
  logic [1:0]  st;
  logic [63:0] val;
  logic [14:0] idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  fpw_walk u_walk (
    .clk_i, .rst_ni, .base_i(base_q),
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .action_i(s_axis_tdata_i[1:0]), .virt_page_i(s_axis_tdata_i[37:2]),
    .phys_page_i(s_axis_tdata_i[77:38]), .perm_i(s_axis_tdata_i[89:78]),
    .create_i(s_axis_tdata_i[90]),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .status_o(st), .entry_value_o(val), .entry_index_o(idx),
    .req_o(req), .rdata_i(rdata)
  );

  // link entry: the walker holds the parent address in raddr during clear
  logic        clr_last;
  logic [39:0] np;
  assign clr_last = req.we && (req.waddr[8:0] == 9'h1ff) && (req.waddr != req.raddr)
                    && (req.raddr[AddrW-1:9] != req.waddr[AddrW-1:9]);
  assign np = base_q + 40'(req.waddr[AddrW-1:9]);

  fpw_store u_store (.clk_i, .req_i(req_w), .rdata_o(rdata));

  logic        link_pend_q;
  logic [AddrW-1:0] link_at_q;
  logic [63:0] link_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_pend_q <= 1'b0;
    end else begin
      link_pend_q <= clr_last;
    end
  end
  always_ff @(posedge clk_i) begin
    link_at_q  <= req.raddr;
    link_val_q <= {12'd0, np, 12'd0} | FlagLink;
  end

  always_comb begin
    req_w = req;
    if (link_pend_q) begin
      req_w.we    = 1'b1;
      req_w.waddr = link_at_q;
      req_w.wdata = link_val_q;
    end
  end

  assign m_axis_tdata_o = {7'd0, idx, val, st};

endmodule
